// ===== rtl/sorted_static_linked_list_unit_defines.svh =====
// Assertion macros shared by the sorted list unit RTL.
`ifndef SORTED_STATIC_LINKED_LIST_UNIT_DEFINES_SVH
`define SORTED_STATIC_LINKED_LIST_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define SSLL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define SSLL_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ssll_pkg.sv =====
// Package: sizes, codes, beat types and helpers of the sorted list unit.
`timescale 1ns / 1ps

package ssll_pkg;

    // Store geometry; the null link is MAX_ENTRIES
    localparam int MAX_ENTRIES = 64;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int LINK_W      = $clog2(MAX_ENTRIES + 1);
    localparam int VAL_W       = 32;

    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(MAX_ENTRIES);

    // Request codes
    localparam logic [1:0] REQ_APPEND = 2'd0;
    localparam logic [1:0] REQ_INSERT = 2'd1;
    localparam logic [1:0] REQ_SEARCH = 2'd2;
    localparam logic [1:0] REQ_DELETE = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_DUP     = 2'd2;
    localparam logic [1:0] ST_MISSING = 2'd3;

    // Request beat
    typedef struct packed {
        logic [1:0]              req_type;
        logic signed [VAL_W-1:0] key_value;
    } req_t;

    // Result beat
    typedef struct packed {
        logic [1:0]        status;
        logic [IDX_W-1:0]  slot_index;
        logic [LINK_W-1:0] list_length;
    } rsp_t;

    // Access bundle from the sequencer to the slot store
    typedef struct packed {
        logic [IDX_W-1:0]        rd_addr;
        logic                    val_we;
        logic [IDX_W-1:0]        val_addr;
        logic signed [VAL_W-1:0] val_data;
        logic                    link_we;
        logic [IDX_W-1:0]        link_addr;
        logic [LINK_W-1:0]       link_data;
    } store_cmd_t;

    // True when a link names a real slot
    function automatic logic is_slot(input logic [LINK_W-1:0] p);
        return p < NULL_LINK;
    endfunction

endpackage

// ===== rtl/ssll_store.sv =====
// Slot store: value memory and link memory, one shared read address, registered reads.
`timescale 1ns / 1ps

module ssll_store (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ssll_pkg::store_cmd_t                cmd,
    output logic signed [ssll_pkg::VAL_W-1:0]   rd_value,
    output logic [ssll_pkg::LINK_W-1:0]         rd_link
);

    logic signed [ssll_pkg::VAL_W-1:0] value_mem [ssll_pkg::MAX_ENTRIES];
    logic [ssll_pkg::LINK_W-1:0]       link_mem  [ssll_pkg::MAX_ENTRIES];
    logic [ssll_pkg::MAX_ENTRIES-1:0]  link_valid_reg;
    logic signed [ssll_pkg::VAL_W-1:0] rd_value_reg;
    logic [ssll_pkg::LINK_W-1:0]       rd_link_reg;

    // Value memory: one write, one read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.val_we)
        begin
            value_mem[cmd.val_addr] <= cmd.val_data;
        end
        rd_value_reg <= value_mem[cmd.rd_addr];
    end

    // Link memory; an unwritten entry reads as its reset link, slot plus one
    always_ff @(posedge clk)
    begin
        if (cmd.link_we)
        begin
            link_mem[cmd.link_addr] <= cmd.link_data;
        end
        if (link_valid_reg[cmd.rd_addr])
        begin
            rd_link_reg <= link_mem[cmd.rd_addr];
        end
        else
        begin
            rd_link_reg <= ssll_pkg::LINK_W'(cmd.rd_addr) + ssll_pkg::LINK_W'(1);
        end
    end

    // Written marks for the link memory
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_valid_reg <= '0;
        end
        else if (cmd.link_we)
        begin
            link_valid_reg[cmd.link_addr] <= 1'b1;
        end
    end

    assign rd_value = rd_value_reg;
    assign rd_link  = rd_link_reg;

endmodule

// ===== rtl/sorted_static_linked_list_unit.sv =====
// Top level: request sequencer of the sorted list unit.
`timescale 1ns / 1ps
`include "sorted_static_linked_list_unit_defines.svh"

// Sorted list of up to 64 signed 32-bit values held in a slot store with a
// free-slot chain. A request is taken when start is high and busy is low; its
// result appears on result, marked by done for one cycle, and must be taken then.
// Search, delete and sorted insert walk the list from the head, one node per
// cycle through the store's registered read port, stopping at the first value
// not less than the key; append walks to the tail. A walk passes at most 64
// nodes on a search or delete that misses and at most 63 otherwise. busy falls
// as the result appears, so the next request can be taken at the edge that
// takes the result. A full store answers append and insert straight from idle,
// without raising busy. No clearing pass is needed after reset.
module sorted_static_linked_list_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  ssll_pkg::req_t request,
    output logic           busy,
    output logic           done,
    output ssll_pkg::rsp_t result
);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_WALK    = 6'b000010,
        S_ALLOC   = 6'b000100,
        S_SPLICE  = 6'b001000,
        S_UNLINK  = 6'b010000,
        S_RELEASE = 6'b100000
    } state_t;

    state_t                              state_reg, state_next;
    logic [1:0]                          req_type_reg, req_type_next;
    logic signed [ssll_pkg::VAL_W-1:0]   key_reg, key_next;
    logic [ssll_pkg::LINK_W-1:0]         cur_reg, cur_next;
    logic [ssll_pkg::LINK_W-1:0]         prev_reg, prev_next;
    logic [ssll_pkg::LINK_W-1:0]         succ_reg, succ_next;
    logic [ssll_pkg::LINK_W-1:0]         walk_n_reg, walk_n_next;
    logic [ssll_pkg::IDX_W-1:0]          slot_reg, slot_next;
    logic [ssll_pkg::LINK_W-1:0]         list_head_reg, list_head_next;
    logic [ssll_pkg::LINK_W-1:0]         free_head_reg, free_head_next;
    logic [ssll_pkg::LINK_W-1:0]         count_reg, count_next;
    logic                                done_reg, done_next;
    ssll_pkg::rsp_t                      result_reg, result_next;

    ssll_pkg::store_cmd_t                cmd;
    logic signed [ssll_pkg::VAL_W-1:0]   rd_value;
    logic [ssll_pkg::LINK_W-1:0]         rd_link;

    logic                                accept;
    logic                                cur_ok;
    logic                                go_on;
    logic                                hit;

    ssll_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .rd_value (rd_value),
        .rd_link  (rd_link)
    );

    assign accept = start && (state_reg == S_IDLE);

    // Walk decisions on the node whose read data has just arrived
    assign cur_ok = ssll_pkg::is_slot(cur_reg)
                    && (walk_n_reg < ssll_pkg::LINK_W'(ssll_pkg::MAX_ENTRIES));
    assign go_on  = cur_ok && ((req_type_reg == ssll_pkg::REQ_APPEND) || (rd_value < key_reg));
    assign hit    = cur_ok && (rd_value == key_reg);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        req_type_next  = req_type_reg;
        key_next       = key_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        succ_next      = succ_reg;
        walk_n_next    = walk_n_reg;
        slot_next      = slot_reg;
        list_head_next = list_head_reg;
        free_head_next = free_head_reg;
        count_next     = count_reg;
        done_next      = 1'b0;
        result_next    = result_reg;

        cmd            = '0;
        cmd.rd_addr    = cur_reg[ssll_pkg::IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_type_next = request.req_type;
                    key_next      = request.key_value;
                    if ((request.req_type inside {ssll_pkg::REQ_APPEND, ssll_pkg::REQ_INSERT})
                        && !ssll_pkg::is_slot(free_head_reg))
                    begin
                        done_next               = 1'b1;
                        result_next.status      = ssll_pkg::ST_FULL;
                        result_next.slot_index  = '0;
                        result_next.list_length = count_reg;
                    end
                    else
                    begin
                        cur_next    = list_head_reg;
                        prev_next   = ssll_pkg::NULL_LINK;
                        walk_n_next = '0;
                        cmd.rd_addr = list_head_reg[ssll_pkg::IDX_W-1:0];
                        state_next  = S_WALK;
                    end
                end
            end

            S_WALK:
            begin
                if (go_on)
                begin
                    // step to the successor and fetch it
                    prev_next   = cur_reg;
                    cur_next    = rd_link;
                    walk_n_next = walk_n_reg + ssll_pkg::LINK_W'(1);
                    cmd.rd_addr = rd_link[ssll_pkg::IDX_W-1:0];
                end
                else
                begin
                    case (req_type_reg)
                        ssll_pkg::REQ_APPEND:
                        begin
                            cmd.rd_addr = free_head_reg[ssll_pkg::IDX_W-1:0];
                            state_next  = S_ALLOC;
                        end
                        ssll_pkg::REQ_INSERT:
                        begin
                            if (hit)
                            begin
                                done_next               = 1'b1;
                                result_next.status      = ssll_pkg::ST_DUP;
                                result_next.slot_index  = '0;
                                result_next.list_length = count_reg;
                                state_next              = S_IDLE;
                            end
                            else
                            begin
                                cmd.rd_addr = free_head_reg[ssll_pkg::IDX_W-1:0];
                                state_next  = S_ALLOC;
                            end
                        end
                        default:
                        begin
                            // search and delete
                            if (hit && (req_type_reg == ssll_pkg::REQ_DELETE))
                            begin
                                succ_next  = rd_link;
                                state_next = S_UNLINK;
                            end
                            else
                            begin
                                done_next               = 1'b1;
                                result_next.status      = hit ? ssll_pkg::ST_OK
                                                              : ssll_pkg::ST_MISSING;
                                result_next.slot_index  = hit ? cur_reg[ssll_pkg::IDX_W-1:0]
                                                              : '0;
                                result_next.list_length = count_reg;
                                state_next              = S_IDLE;
                            end
                        end
                    endcase
                end
            end

            S_ALLOC:
            begin
                // pop the free chain, fill the new slot
                slot_next      = free_head_reg[ssll_pkg::IDX_W-1:0];
                free_head_next = rd_link;
                cmd.val_we     = 1'b1;
                cmd.val_addr   = free_head_reg[ssll_pkg::IDX_W-1:0];
                cmd.val_data   = key_reg;
                cmd.link_we    = 1'b1;
                cmd.link_addr  = free_head_reg[ssll_pkg::IDX_W-1:0];
                cmd.link_data  = (req_type_reg == ssll_pkg::REQ_APPEND) ? ssll_pkg::NULL_LINK
                                                                        : cur_reg;
                state_next     = S_SPLICE;
            end

            S_SPLICE:
            begin
                // hook the new slot behind its predecessor
                if (ssll_pkg::is_slot(prev_reg))
                begin
                    cmd.link_we   = 1'b1;
                    cmd.link_addr = prev_reg[ssll_pkg::IDX_W-1:0];
                    cmd.link_data = ssll_pkg::LINK_W'(slot_reg);
                end
                else
                begin
                    list_head_next = ssll_pkg::LINK_W'(slot_reg);
                end
                count_next              = count_reg + ssll_pkg::LINK_W'(1);
                done_next               = 1'b1;
                result_next.status      = ssll_pkg::ST_OK;
                result_next.slot_index  = slot_reg;
                result_next.list_length = count_next;
                state_next              = S_IDLE;
            end

            S_UNLINK:
            begin
                // bypass the victim
                if (ssll_pkg::is_slot(prev_reg))
                begin
                    cmd.link_we   = 1'b1;
                    cmd.link_addr = prev_reg[ssll_pkg::IDX_W-1:0];
                    cmd.link_data = succ_reg;
                end
                else
                begin
                    list_head_next = succ_reg;
                end
                state_next = S_RELEASE;
            end

            S_RELEASE:
            begin
                // push the victim onto the free chain
                cmd.link_we    = 1'b1;
                cmd.link_addr  = cur_reg[ssll_pkg::IDX_W-1:0];
                cmd.link_data  = free_head_reg;
                free_head_next = cur_reg;
                if (count_reg != '0)
                begin
                    count_next = count_reg - ssll_pkg::LINK_W'(1);
                end
                done_next               = 1'b1;
                result_next.status      = ssll_pkg::ST_OK;
                result_next.slot_index  = cur_reg[ssll_pkg::IDX_W-1:0];
                result_next.list_length = count_next;
                state_next              = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            list_head_reg <= ssll_pkg::NULL_LINK;
            free_head_reg <= '0;
            count_reg     <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            list_head_reg <= list_head_next;
            free_head_reg <= free_head_next;
            count_reg     <= count_next;
            done_reg      <= done_next;
        end
    end

    // Working registers of the current request
    always_ff @(posedge clk)
    begin
        req_type_reg <= req_type_next;
        key_reg      <= key_next;
        cur_reg      <= cur_next;
        prev_reg     <= prev_next;
        succ_reg     <= succ_next;
        walk_n_reg   <= walk_n_next;
        slot_reg     <= slot_next;
        result_reg   <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // Checks; the free chain runs dry at the end of S_ALLOC, and the count catches up only in S_SPLICE
    `SSLL_ASSERT_NXT(a_done_only_on_work, (state_reg == S_IDLE) && !start, !done_reg, "done without a request")
    `SSLL_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= ssll_pkg::LINK_W'(ssll_pkg::MAX_ENTRIES), "list length beyond store size")
    `SSLL_ASSERT_IMP(a_free_empty_is_full, !ssll_pkg::is_slot(free_head_reg) && (state_reg != S_SPLICE), count_reg == ssll_pkg::LINK_W'(ssll_pkg::MAX_ENTRIES), "free chain empty with free slots left")
    `SSLL_ASSERT_IMP(a_fail_slot_zero, done_reg && (result_reg.status != ssll_pkg::ST_OK), result_reg.slot_index == '0, "failed request reports a slot")
    `SSLL_ASSERT_IMP(a_walk_bound, state_reg == S_WALK, walk_n_reg <= ssll_pkg::LINK_W'(ssll_pkg::MAX_ENTRIES), "walk ran past the store size")

endmodule

// ===== test/tb_sorted_static_linked_list_unit.sv =====
// Testbench: random and directed requests against a predicted image of the sorted slot list.
`timescale 1ns / 1ps

module tb_sorted_static_linked_list_unit;

    import ssll_pkg::*;

    localparam int RANDOM_BEATS = 1680;
    localparam int FILL_BEATS   = 74;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE_WAIT  = 80;
    localparam int POOL_DEPTH   = 64;

    localparam logic signed [VAL_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] KEY_MAX = 32'sh7fff_ffff;

    // One queued request with its pacing
    typedef struct {
        req_t        beat;
        int unsigned idle_pct;
        bit          drain_first;
    } stim_t;

    logic clk;
    logic rst_n   = 1'b0;
    logic start   = 1'b0;
    req_t request = '0;
    logic busy;
    logic done;
    rsp_t result;

    stim_t       pending_beats[$];
    rsp_t        awaited_outcomes[$];
    int          key_pool[$];
    int unsigned queued_total   = 0;
    int unsigned issued_count   = 0;
    int unsigned accepted_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned fail_count     = 0;

    // Predicted image of the slot store
    logic signed [VAL_W-1:0] slot_value [MAX_ENTRIES];
    logic [LINK_W-1:0]       slot_link  [MAX_ENTRIES];
    logic [LINK_W-1:0]       head_link;
    logic [LINK_W-1:0]       free_link;
    logic [LINK_W-1:0]       linked_count;

    sorted_static_linked_list_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .request(request),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    // Clock, 10 ns period
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Free chain in slot order, empty list
    function automatic void clear_list_image();
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            slot_value[i] = '0;
            slot_link[i]  = LINK_W'(i + 1);
        end
        slot_link[MAX_ENTRIES-1] = NULL_LINK;
        head_link    = NULL_LINK;
        free_link    = '0;
        linked_count = '0;
    endfunction

    // Pops the head of the free chain; caller checks it is not empty
    function automatic logic [LINK_W-1:0] claim_free_slot();
        logic [LINK_W-1:0] s;
        s         = free_link;
        free_link = slot_link[s[IDX_W-1:0]];
        return s;
    endfunction

    // Walks past every node below the key, at most MAX_ENTRIES nodes
    function automatic logic [LINK_W-1:0] walk_below(input logic signed [VAL_W-1:0] key,
                                                     output logic [LINK_W-1:0] prev);
        logic [LINK_W-1:0] cur;
        int                n;
        cur  = head_link;
        prev = NULL_LINK;
        n    = 0;
        while (cur < NULL_LINK && n < MAX_ENTRIES && slot_value[cur[IDX_W-1:0]] < key)
        begin
            prev = cur;
            cur  = slot_link[cur[IDX_W-1:0]];
            n++;
        end
        if (n >= MAX_ENTRIES)
            cur = NULL_LINK;
        return cur;
    endfunction

    // Applies one request to the image and returns the outcome it gives
    function automatic rsp_t apply_list_op(input req_t r);
        rsp_t              o;
        logic [LINK_W-1:0] prev;
        logic [LINK_W-1:0] cur;
        logic [LINK_W-1:0] s;
        int                n;
        o.status     = ST_OK;
        o.slot_index = '0;
        case (r.req_type)
            REQ_APPEND:
            begin
                if (free_link >= NULL_LINK)
                    o.status = ST_FULL;
                else
                begin
                    prev = NULL_LINK;
                    cur  = head_link;
                    n    = 0;
                    while (cur < NULL_LINK && n < MAX_ENTRIES)
                    begin
                        prev = cur;
                        cur  = slot_link[cur[IDX_W-1:0]];
                        n++;
                    end
                    s = claim_free_slot();
                    slot_value[s[IDX_W-1:0]] = r.key_value;
                    slot_link[s[IDX_W-1:0]]  = NULL_LINK;
                    if (prev < NULL_LINK)
                        slot_link[prev[IDX_W-1:0]] = s;
                    else
                        head_link = s;
                    linked_count++;
                    o.slot_index = s[IDX_W-1:0];
                end
            end
            REQ_INSERT:
            begin
                if (free_link >= NULL_LINK)
                    o.status = ST_FULL;
                else
                begin
                    cur = walk_below(r.key_value, prev);
                    if (cur < NULL_LINK && slot_value[cur[IDX_W-1:0]] == r.key_value)
                        o.status = ST_DUP;
                    else
                    begin
                        s = claim_free_slot();
                        slot_value[s[IDX_W-1:0]] = r.key_value;
                        if (prev < NULL_LINK)
                        begin
                            slot_link[s[IDX_W-1:0]]    = slot_link[prev[IDX_W-1:0]];
                            slot_link[prev[IDX_W-1:0]] = s;
                        end
                        else
                        begin
                            slot_link[s[IDX_W-1:0]] = head_link;
                            head_link               = s;
                        end
                        linked_count++;
                        o.slot_index = s[IDX_W-1:0];
                    end
                end
            end
            default:
            begin
                // search and delete share the walk
                cur = walk_below(r.key_value, prev);
                if (cur < NULL_LINK && slot_value[cur[IDX_W-1:0]] == r.key_value)
                begin
                    o.slot_index = cur[IDX_W-1:0];
                    if (r.req_type == REQ_DELETE)
                    begin
                        if (prev < NULL_LINK)
                            slot_link[prev[IDX_W-1:0]] = slot_link[cur[IDX_W-1:0]];
                        else
                            head_link = slot_link[cur[IDX_W-1:0]];
                        slot_link[cur[IDX_W-1:0]] = free_link;
                        free_link = cur;
                        if (linked_count > 0)
                            linked_count--;
                    end
                end
                else
                    o.status = ST_MISSING;
            end
        endcase
        o.list_length = linked_count;
        return o;
    endfunction

    // Sender pacing: 32 % idle, then 54 %, then none
    function automatic int unsigned idle_for(input int unsigned idx);
        if (idx < (RANDOM_BEATS + 25) / 3)
            return 32;
        if (idx < 2 * (RANDOM_BEATS + 25) / 3)
            return 54;
        return 0;
    endfunction

    task automatic queue_beat(input logic [1:0] op, input logic signed [VAL_W-1:0] key,
                              input bit drain);
        stim_t b;
        b.beat.req_type  = op;
        b.beat.key_value = key;
        b.idle_pct       = idle_for(queued_total);
        b.drain_first    = drain;
        pending_beats.push_back(b);
        queued_total++;
        if (op == REQ_APPEND || op == REQ_INSERT)
        begin
            key_pool.push_back(int'(key));
            if (key_pool.size() > POOL_DEPTH)
                void'(key_pool.pop_front());
        end
    endtask

    // Key mix: recent keys, a narrow band, full range and the extremes
    function automatic logic signed [VAL_W-1:0] pick_key(input int unsigned pool_pct);
        int unsigned r;
        r = $urandom_range(99);
        if (key_pool.size() > 0 && r < pool_pct)
            return key_pool[$urandom_range(key_pool.size() - 1)];
        r = $urandom_range(99);
        if (r < 45)
            return int'($urandom_range(80)) - 40;
        if (r < 80)
            return $urandom();
        case ($urandom_range(3))
            0:       return KEY_MIN;
            1:       return KEY_MAX;
            2:       return '0;
            default: return -1;
        endcase
    endfunction

    function automatic logic [1:0] pick_op(input bit growing);
        int unsigned r;
        r = $urandom_range(99);
        if (growing)
            return (r < 25) ? REQ_APPEND : (r < 65) ? REQ_INSERT :
                   (r < 85) ? REQ_SEARCH : REQ_DELETE;
        return (r < 5) ? REQ_APPEND : (r < 20) ? REQ_INSERT :
               (r < 40) ? REQ_SEARCH : REQ_DELETE;
    endfunction

    task automatic check_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            fail_count++;
        end
    endtask

    // Driver: presents the next beat at the falling edge, holds it until taken
    always @(negedge clk)
    begin
        logic  go;
        stim_t nxt;
        go = 1'b0;
        if (rst_n && issued_count == accepted_count && pending_beats.size() > 0)
        begin
            if ((!pending_beats[0].drain_first || awaited_outcomes.size() == 0)
                && $urandom_range(99) >= pending_beats[0].idle_pct)
            begin
                nxt = pending_beats.pop_front();
                go  = 1'b1;
            end
        end
        if (go)
        begin
            request <= nxt.beat;
            issued_count++;
        end
        if (rst_n && issued_count == accepted_count + (go ? 1 : 0))
            start <= go;
    end

    // Monitor: checks results first, then records the beat taken at this edge
    always @(posedge clk)
    begin
        rsp_t want;
        cycle_count++;
        if (rst_n)
        begin
            if (done)
            begin
                if (awaited_outcomes.size() == 0)
                begin
                    $display("%0t: result with none awaited, actual status %0d slot %0d length %0d",
                             $time, result.status, result.slot_index, result.list_length);
                    fail_count++;
                end
                else
                begin
                    want = awaited_outcomes.pop_front();
                    check_field("status", 8'(want.status), 8'(result.status));
                    check_field("slot_index", 8'(want.slot_index), 8'(result.slot_index));
                    check_field("list_length", 8'(want.list_length), 8'(result.list_length));
                end
            end
            if (start && !busy)
            begin
                awaited_outcomes.push_back(apply_list_op(request));
                accepted_count++;
            end
        end
    end

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int unsigned made;
        int unsigned seg_len;
        bit          growing;
        logic [1:0]  op;

        clear_list_image();

        // Directed: empty list, extremes, duplicates, unsorted tail, deletes
        queue_beat(REQ_SEARCH, 7, 1'b0);
        queue_beat(REQ_DELETE, 7, 1'b0);
        queue_beat(REQ_INSERT, 0, 1'b0);
        queue_beat(REQ_INSERT, KEY_MAX, 1'b0);
        queue_beat(REQ_INSERT, KEY_MIN, 1'b0);
        queue_beat(REQ_INSERT, -1, 1'b0);
        queue_beat(REQ_INSERT, 1, 1'b0);
        queue_beat(REQ_INSERT, 0, 1'b0);
        queue_beat(REQ_INSERT, KEY_MIN, 1'b0);
        queue_beat(REQ_SEARCH, KEY_MIN, 1'b0);
        queue_beat(REQ_SEARCH, KEY_MAX, 1'b0);
        queue_beat(REQ_SEARCH, 5, 1'b0);
        queue_beat(REQ_APPEND, -100, 1'b0);
        queue_beat(REQ_SEARCH, -100, 1'b0);
        queue_beat(REQ_DELETE, -100, 1'b0);
        queue_beat(REQ_APPEND, KEY_MAX, 1'b0);
        queue_beat(REQ_DELETE, KEY_MIN, 1'b0);
        queue_beat(REQ_DELETE, 0, 1'b0);
        queue_beat(REQ_DELETE, KEY_MAX, 1'b0);
        queue_beat(REQ_SEARCH, KEY_MAX, 1'b0);
        queue_beat(REQ_DELETE, -1, 1'b0);
        queue_beat(REQ_DELETE, 1, 1'b0);
        queue_beat(REQ_DELETE, KEY_MAX, 1'b0);
        queue_beat(REQ_DELETE, -100, 1'b0);
        queue_beat(REQ_SEARCH, -100, 1'b0);

        // Fill past capacity so append and insert meet a full store
        for (int i = 0; i < FILL_BEATS; i++)
            queue_beat(($urandom_range(99) < 60) ? REQ_APPEND : REQ_INSERT, $urandom(),
                       i == 0);
        made = FILL_BEATS;

        // Alternating growth and shrink stretches with random content
        while (made < RANDOM_BEATS)
        begin
            seg_len = $urandom_range(60, 20);
            growing = $urandom_range(1);
            for (int i = 0; i < seg_len && made < RANDOM_BEATS; i++)
            begin
                op = pick_op(growing);
                queue_beat(op, pick_key((op == REQ_SEARCH || op == REQ_DELETE) ? 55 : 10),
                           $urandom_range(249) == 0);
                made++;
            end
        end

        // Predictor state back to reset before any beat is taken
        clear_list_image();

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (!(accepted_count == queued_total && awaited_outcomes.size() == 0))
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ssll_pkg.sv
rtl/ssll_store.sv
rtl/sorted_static_linked_list_unit.sv
test/tb_sorted_static_linked_list_unit.sv
